// File: sv/bqf_pkg.sv
package bqf_pkg;

	// Register file
	localparam int CFG_BITS     = 32;
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FILTER_MODE = 2'd0,
		REG_COS_W0      = 2'd1,
		REG_ALPHA       = 2'd2
	} reg_idx_t;

	// Normalized coefficients: signed, 34 bits
	localparam int COEF_BITS = 34;
	localparam int NUM_COEFS = 5;
	localparam int COEF_IDX_BITS = 3;

	localparam logic [COEF_IDX_BITS-1:0] K_B0 = 3'd0;
	localparam logic [COEF_IDX_BITS-1:0] K_B1 = 3'd1;
	localparam logic [COEF_IDX_BITS-1:0] K_B2 = 3'd2;
	localparam logic [COEF_IDX_BITS-1:0] K_A1 = 3'd3;
	localparam logic [COEF_IDX_BITS-1:0] K_A2 = 3'd4;
	// one step past the last tap: pipeline drain
	localparam logic [COEF_IDX_BITS-1:0] K_DRAIN = 3'd5;

	// Divider: numerator magnitude, divisor, quotient and dividend widths
	localparam int NUM_BITS = 35;
	localparam int MAG_BITS = 34;
	localparam int DEN_BITS = 34;
	localparam int QUO_BITS = 34;
	localparam int DVD_BITS = 64;
	localparam int ITER_BITS = 6;

	// 1.0 in the Q2.30 register format
	localparam logic [NUM_BITS-1:0] CFG_ONE = 35'h0_4000_0000;

	// warm-up length in samples
	localparam logic [1:0] WARMUP_LEN = 2'd3;

endpackage

// File: sv/biquad_low_high_cut_filter_unit.sv
// Second-order high-pass / low-pass biquad (cookbook form) on signed samples.
// Software writes filter_mode, cos_w0 and alpha over the write port; after
// reset and after every register write the block divides the five cookbook
// coefficients by 1+alpha with one shift-subtract divider, one quotient bit per
// cycle, for four divisions (b2 copies b0), with in_ready low meanwhile. A
// sample word then passes from acceptance through ST_MAC (five products through
// the single multiplier and accumulator plus a drain step), ST_ROUND (rounding
// and saturation) and ST_RESULT, which hands the word to the output register.
// The output register lets a new sample be taken while the last result still
// waits. The first three samples return zero and seed the output history with
// the raw input.
module biquad_low_high_cut_filter_unit #(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [bqf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bqf_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [SAMPLE_BITS-1:0]      sample_out
);
	import bqf_pkg::*;

	localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_W  = PROD_W + 3;
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
	localparam logic [ITER_BITS-1:0] LAST_ITER = ITER_BITS'(QUO_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DIV_STORE,
		ST_MAC,
		ST_ROUND,
		ST_RESULT
	} state_t;

	state_t state_q;

	// configuration registers
	logic                        mode_q;
	logic signed [CFG_BITS-1:0]  cos_w0_q;
	logic [CFG_BITS-1:0]         alpha_q;

	// sequencer
	logic [COEF_IDX_BITS-1:0]    div_k_q;
	logic [ITER_BITS-1:0]        iter_q;
	logic [COEF_IDX_BITS-1:0]    tap_q;
	logic [1:0]                  warm_q;
	logic                        warm_item_q;
	logic                        out_valid_q;

	// datapath
	logic signed [COEF_BITS-1:0]   coef_q [NUM_COEFS];
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] xh0_q, xh1_q, yh0_q, yh1_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic signed [PROD_W-1:0]      p_s1;
	logic                          sub_s1;
	logic signed [ACC_W-1:0]       acc_q;
	logic [DEN_BITS-1:0]           den_q;
	logic [DEN_BITS-1:0]           rem_q;
	logic [QUO_BITS-1:0]           dq_q;
	logic                          neg_q;

	logic cfg_hit;
	logic out_load;
	assign cfg_hit  = cfg_write && (cfg_index == REG_FILTER_MODE || cfg_index == REG_COS_W0 ||
		cfg_index == REG_ALPHA);
	assign out_load = (state_q == ST_RESULT) && !cfg_hit && (!out_valid_q || out_ready);

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// divider setup: numerator and divisor for the coefficient in hand
	logic signed [NUM_BITS-1:0] c_ext, a_ext, bsum, num;
	logic [MAG_BITS-1:0]        mag;
	logic [DEN_BITS-1:0]        a0, den;
	logic [DVD_BITS-1:0]        dividend;

	always_comb begin
		c_ext = NUM_BITS'(cos_w0_q);
		a_ext = $signed({{(NUM_BITS - CFG_BITS){1'b0}}, alpha_q});
		bsum  = mode_q ? ($signed(CFG_ONE) - c_ext) : ($signed(CFG_ONE) + c_ext);
		unique case (div_k_q)
			K_B0:    num = bsum;
			K_B1:    num = mode_q ? bsum : -bsum;
			K_A1:    num = -(c_ext <<< 1);
			K_A2:    num = $signed(CFG_ONE) - a_ext;
			default: num = bsum;
		endcase
		mag      = num[NUM_BITS-1] ? MAG_BITS'(-num) : MAG_BITS'(num);
		a0       = DEN_BITS'(CFG_ONE) + DEN_BITS'(alpha_q);
		den      = (div_k_q == K_B0) ? (a0 << 1) : a0;
		dividend = (DVD_BITS'(mag) << COEF_FRAC_BITS) + DVD_BITS'(den >> 1);
	end

	// divider step: one quotient bit
	logic [DEN_BITS:0] rs, rdiff;
	logic              rge;
	always_comb begin
		rs    = {rem_q, dq_q[QUO_BITS-1]};
		rge   = rs >= {1'b0, den_q};
		rdiff = rs - {1'b0, den_q};
	end

	// tap select for the multiplier
	logic signed [COEF_BITS-1:0]   mul_a;
	logic signed [SAMPLE_BITS-1:0] mul_b;
	logic signed [PROD_W-1:0]      prod;
	always_comb begin
		unique case (tap_q)
			K_B0:    begin mul_a = coef_q[0]; mul_b = x_q;   end
			K_B1:    begin mul_a = coef_q[1]; mul_b = xh0_q; end
			K_B2:    begin mul_a = coef_q[2]; mul_b = xh1_q; end
			K_A1:    begin mul_a = coef_q[3]; mul_b = yh0_q; end
			K_A2:    begin mul_a = coef_q[4]; mul_b = yh1_q; end
			default: begin mul_a = coef_q[0]; mul_b = x_q;   end
		endcase
		prod = mul_a * mul_b;
	end

	// round to nearest (ties up) and saturate
	logic signed [ACC_W-1:0]       rnd_sum, rnd_sh;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	always_comb begin
		rnd_sum = acc_q + $signed(RND_HALF);
		rnd_sh  = rnd_sum >>> COEF_FRAC_BITS;
		if (rnd_sh > SAT_MAX) begin
			y_sat = SAT_MAX[SAMPLE_BITS-1:0];
		end else if (rnd_sh < SAT_MIN) begin
			y_sat = SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			y_sat = rnd_sh[SAMPLE_BITS-1:0];
		end
	end

	// sequencer, registers, history and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DIV_LOAD;
			mode_q      <= 1'b0;
			cos_w0_q    <= CFG_BITS'(CFG_ONE);
			alpha_q     <= '0;
			div_k_q     <= K_B0;
			iter_q      <= '0;
			tap_q       <= K_B0;
			warm_q      <= '0;
			warm_item_q <= 1'b0;
			out_valid_q <= 1'b0;
			xh0_q       <= '0;
			xh1_q       <= '0;
			yh0_q       <= '0;
			yh1_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				unique case (cfg_index)
					REG_FILTER_MODE: mode_q   <= cfg_data[0];
					REG_COS_W0:      cos_w0_q <= cfg_data;
					REG_ALPHA:       alpha_q  <= cfg_data;
					default:         ;
				endcase
				// coefficients follow every write
				state_q <= ST_DIV_LOAD;
				div_k_q <= K_B0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (in_valid) begin
							warm_item_q <= (warm_q != WARMUP_LEN);
							tap_q       <= K_B0;
							state_q     <= (warm_q != WARMUP_LEN) ? ST_RESULT : ST_MAC;
						end
					end
					ST_DIV_LOAD: begin
						iter_q  <= '0;
						state_q <= ST_DIV_RUN;
					end
					ST_DIV_RUN: begin
						iter_q <= iter_q + 1'b1;
						if (iter_q == LAST_ITER) begin
							state_q <= ST_DIV_STORE;
						end
					end
					ST_DIV_STORE: begin
						if (div_k_q == K_A2) begin
							state_q <= ST_IDLE;
						end else begin
							div_k_q <= (div_k_q == K_B1) ? K_A1 : div_k_q + 1'b1;
							state_q <= ST_DIV_LOAD;
						end
					end
					ST_MAC: begin
						tap_q <= tap_q + 1'b1;
						if (tap_q == K_DRAIN) begin
							state_q <= ST_ROUND;
						end
					end
					ST_ROUND: begin
						state_q <= ST_RESULT;
					end
					ST_RESULT: begin
						if (out_load) begin
							out_valid_q <= 1'b1;
							xh1_q       <= xh0_q;
							xh0_q       <= x_q;
							yh1_q       <= yh0_q;
							yh0_q       <= warm_item_q ? x_q : y_q;
							if (warm_item_q) begin
								warm_q <= warm_q + 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q   <= sample_in;
			acc_q <= '0;
		end
		if (state_q == ST_DIV_LOAD) begin
			neg_q <= num[NUM_BITS-1];
			den_q <= den;
			rem_q <= DEN_BITS'(dividend >> QUO_BITS);
			dq_q  <= dividend[QUO_BITS-1:0];
		end
		if (state_q == ST_DIV_RUN) begin
			rem_q <= rge ? rdiff[DEN_BITS-1:0] : rs[DEN_BITS-1:0];
			dq_q  <= {dq_q[QUO_BITS-2:0], rge};
		end
		if (state_q == ST_DIV_STORE) begin
			coef_q[div_k_q] <= neg_q ? -$signed(dq_q) : $signed(dq_q);
			if (div_k_q == K_B0) begin
				coef_q[K_B2] <= neg_q ? -$signed(dq_q) : $signed(dq_q);
			end
		end
		if (state_q == ST_MAC) begin
			if (tap_q != K_DRAIN) begin
				p_s1   <= prod;
				sub_s1 <= (tap_q == K_A1) || (tap_q == K_A2);
			end
			if (tap_q != K_B0) begin
				acc_q <= sub_s1 ? acc_q - ACC_W'(p_s1) : acc_q + ACC_W'(p_s1);
			end
		end
		if (state_q == ST_ROUND) begin
			y_q <= y_sat;
		end
		if (out_load) begin
			sample_out_q <= warm_item_q ? '0 : y_q;
		end
	end

`ifndef SYNTHESIS
	a_accept_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !cfg_hit |=> !in_ready)
		else $error("in_ready still high after a word was accepted");

	a_cfg_recomputes: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> !in_ready && state_q == ST_DIV_LOAD)
		else $error("register write did not restart coefficient update");

	a_warm_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		warm_q != WARMUP_LEN |=> warm_q >= $past(warm_q))
		else $error("warm-up counter went backwards");

	a_warm_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && warm_item_q |=> out_valid && sample_out == '0)
		else $error("warm-up word is not zero");
`endif

endmodule
